@@ hw/rtl/tgst_pkg.sv @@
// types, codes and constants shared by the two-gate speed timer
// no dependencies; imported by tgst_div and two_gate_speed_timer

package tgst_pkg;

  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 28;
  localparam int unsigned TicksW    = 24;
  localparam int unsigned PeriodW   = 17;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIdxW-1:0] REG_PERIOD_TICKS    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TICK_LENGTH_US  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_PERIODS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_NUMERATOR = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FALSE_START     = 3'd4;

  localparam logic [15:0] RST_PERIOD_TICKS    = 16'd10000;
  localparam logic [9:0]  RST_TICK_LENGTH_US  = 10'd100;
  localparam logic [7:0]  RST_TIMEOUT_PERIODS = 8'd3;
  localparam logic [31:0] RST_SPEED_NUMERATOR = 32'd100000000;
  localparam logic [15:0] RST_FALSE_START     = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_ARM   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_DONE    = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_SIMUL   = 2'd3
  } event_e;

  typedef struct packed {
    opcode_e opcode;
    logic    arm_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [31:0] time_us;
    logic [15:0] measure_count;
    logic        armed;
    logic        running;
    logic        led;
    event_e      event_res;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/tgst_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on tgst_pkg for widths and the request and status structs

module tgst_div import tgst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  output div_stat_t            stat_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DivisorW:0] trial;
  logic              ge;
  logic [DivisorW:0] diff;

  always_comb begin
    trial  = {rem_q, quo_q[DividendW-1]};
    ge     = trial >= {1'b0, dvs_q};
    diff   = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DividendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ hw/rtl/two_gate_speed_timer.sv @@
// two-gate speed timer: gate and tick sequencer with config registers
// depends on tgst_pkg and tgst_div

// The result of a tick, start-gate or arm item is registered on the edge that accepts it.
// A stop-gate item that ends a run is worked in steps: the elapsed tick count is formed, then
// the division and the transit time are set up, then the restoring divider runs (one quotient
// bit per cycle), and then the speed is saturated.
// A stop that ends a run with no elapsed ticks forms the tick count and then registers the
// simultaneous-gates code. An ignored stop's result is registered on the accepting edge.
// Speed is computed as numerator / (10 * ticks), which equals the two truncating divisions.
// The input is not ready while a stop is being worked or while the result register holds an
// item that is not taken in the same cycle.

module two_gate_speed_timer import tgst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  logic [15:0] period_q;
  logic [9:0]  tick_len_q;
  logic [7:0]  timeout_q;
  logic [31:0] numer_q;
  logic [15:0] fsc_q;

  state_e      state_q, state_d;
  logic        armed_q, armed_d;
  logic        running_q, running_d;
  logic        lamp_q, lamp_d;
  logic [15:0] sub_q, sub_d;
  logic [7:0]  wrap_q, wrap_d;
  logic [15:0] speed_q, speed_d;
  logic [31:0] time_q, time_d;
  logic [15:0] good_q, good_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;

  logic [PeriodW-1:0]  eff_period;
  logic [PeriodW-1:0]  sub_inc;
  logic [TicksW-1:0]   ticks_full;
  logic [33:0]         time_prod;
  logic [DivisorW-1:0] div_divisor;
  logic                in_fire;
  logic                push;
  event_e              ev;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DividendW-1:0] div_quo;

  tgst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= RST_PERIOD_TICKS;
      tick_len_q <= RST_TICK_LENGTH_US;
      timeout_q  <= RST_TIMEOUT_PERIODS;
      numer_q    <= RST_SPEED_NUMERATOR;
      fsc_q      <= RST_FALSE_START;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD_TICKS:    period_q   <= cfg_wdata_i[15:0];
        REG_TICK_LENGTH_US:  tick_len_q <= cfg_wdata_i[9:0];
        REG_TIMEOUT_PERIODS: timeout_q  <= cfg_wdata_i[7:0];
        REG_SPEED_NUMERATOR: numer_q    <= cfg_wdata_i;
        REG_FALSE_START:     fsc_q      <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign eff_period  = {(period_q == 16'd0), period_q};
  assign sub_inc     = {1'b0, sub_q} + 1'b1;
  assign ticks_full  = wrap_q * eff_period + {8'd0, sub_q};
  assign time_prod   = ticks_q * tick_len_q;
  assign div_divisor = DivisorW'({ticks_q, 3'b000}) + DivisorW'({ticks_q, 1'b0});

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    running_d   = running_q;
    lamp_d      = lamp_q;
    sub_d       = sub_q;
    wrap_d      = wrap_q;
    speed_d     = speed_q;
    time_d      = time_q;
    good_d      = good_q;
    ticks_d     = ticks_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    push        = 1'b0;
    ev          = EV_NONE;
    div_req.start    = 1'b0;
    div_req.dividend = numer_q;
    div_req.divisor  = div_divisor;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.opcode)
            OP_TICK: begin
              push = 1'b1;
              if (running_q) begin
                if (sub_inc >= eff_period) begin
                  sub_d  = '0;
                  wrap_d = wrap_q + 1'b1;
                  if (wrap_d >= timeout_q) begin
                    armed_d   = 1'b0;
                    running_d = 1'b0;
                    lamp_d    = 1'b0;
                    speed_d   = fsc_q;
                    ev        = EV_TIMEOUT;
                  end else begin
                    lamp_d = !lamp_q;
                  end
                end else begin
                  sub_d = sub_inc[15:0];
                end
              end
            end
            OP_START: begin
              push = 1'b1;
              if (armed_q && !running_q) begin
                sub_d     = '0;
                wrap_d    = '0;
                running_d = 1'b1;
                lamp_d    = 1'b1;
              end
            end
            OP_STOP: begin
              if (armed_q && running_q) begin
                armed_d   = 1'b0;
                running_d = 1'b0;
                lamp_d    = 1'b0;
                ticks_d   = ticks_full;
                state_d   = ST_PREP;
              end else begin
                push = 1'b1;
              end
            end
            default: begin
              push    = 1'b1;
              armed_d = in_item_i.arm_value;
            end
          endcase
        end
      end
      ST_PREP: begin
        if (ticks_q == '0) begin
          speed_d = fsc_q - 1'b1;
          ev      = EV_SIMUL;
          push    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          div_req.start = 1'b1;
          time_d  = (time_prod[33:32] != 2'd0) ? 32'hFFFF_FFFF : time_prod[31:0];
          good_d  = good_q + 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          speed_d = (div_quo[31:16] != 16'd0) ? 16'hFFFF : div_quo[15:0];
          ev      = EV_DONE;
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push) begin
      out_valid_d              = 1'b1;
      out_item_d.speed         = speed_d;
      out_item_d.time_us       = time_d;
      out_item_d.measure_count = good_d;
      out_item_d.armed         = armed_d;
      out_item_d.running       = running_d;
      out_item_d.led           = lamp_d;
      out_item_d.event_res     = ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b0;
      running_q   <= 1'b0;
      lamp_q      <= 1'b0;
      sub_q       <= '0;
      wrap_q      <= '0;
      speed_q     <= '0;
      time_q      <= '0;
      good_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      running_q   <= running_d;
      lamp_q      <= lamp_d;
      sub_q       <= sub_d;
      wrap_q      <= wrap_d;
      speed_q     <= speed_d;
      time_q      <= time_d;
      good_q      <= good_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q    <= ticks_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // the divider is running or just finished whenever the sequencer waits on it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("sequencer waits on an idle divider");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the division step");

  // a stop in progress has already ended the run
  a_run_ended: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !armed_q && !running_q && !lamp_q)
    else $error("run flags set while a stop is being worked");

  a_prep_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP |=> (state_q == ST_IDLE && out_valid_q) || state_q == ST_DIV)
    else $error("bad step after stop setup");
`endif

endmodule
